/* src/ycc2rgb_pkg.sv */
// ycc2rgb_pkg: constants shared by the YCbCr to RGB pixel converter
// no dependencies; imported by the two channel interfaces, the sample reducer and the top level
`timescale 1ns / 1ps

package ycc2rgb_pkg;

  localparam int WORD_W   = 16;
  localparam int SAMPLE_W = 8;
  localparam int DIFF_W   = 10;   // sample minus offset, signed
  localparam int ACC_W    = 22;   // products and sums, signed
  localparam int FRAC_BITS = 10;

  // ten-bit words carry the value in bits 15..6
  localparam int TEN_LSB = 6;

  localparam logic [10:0] TEN_FULL_SCALE = 11'd1023;

  localparam logic signed [DIFF_W-1:0] Y_OFFSET = 10'sd16;
  localparam logic signed [DIFF_W-1:0] C_OFFSET = 10'sd128;

  // bt.709 limited range, q10
  localparam logic signed [12:0] COEF_Y    = 13'sd1192;
  localparam logic signed [12:0] COEF_R_CR = 13'sd1836;
  localparam logic signed [12:0] COEF_G_CB = 13'sd218;
  localparam logic signed [12:0] COEF_G_CR = 13'sd546;
  localparam logic signed [12:0] COEF_B_CB = 13'sd2163;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 22'sd512;

endpackage

/* src/ycc2rgb_in_if.sv */
// ycc2rgb_in_if: input pixel channel, valid/ready with luma and chroma words
// depends on ycc2rgb_pkg for the word width
`timescale 1ns / 1ps

interface ycc2rgb_in_if import ycc2rgb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] luma_word;
  logic [WORD_W-1:0] cb_word;
  logic [WORD_W-1:0] cr_word;

  modport source (output valid, output luma_word, output cb_word, output cr_word,
                  input ready);
  modport sink   (input valid, input luma_word, input cb_word, input cr_word,
                  output ready);
endinterface

/* src/ycc2rgb_out_if.sv */
// ycc2rgb_out_if: result pixel channel, valid/ready with 8-bit red, green, blue
// depends on ycc2rgb_pkg for the sample width
`timescale 1ns / 1ps

interface ycc2rgb_out_if import ycc2rgb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red;
  logic [SAMPLE_W-1:0] green;
  logic [SAMPLE_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* src/ycc2rgb_sample.sv */
// ycc2rgb_sample: reduces one sample word to an 8-bit sample
// ten-bit mode scales word[15:6] by 255/1023 with truncation; depends on ycc2rgb_pkg
`timescale 1ns / 1ps

module ycc2rgb_sample import ycc2rgb_pkg::*; (
  input  logic                ten_bit,
  input  logic [WORD_W-1:0]   word,
  output logic [SAMPLE_W-1:0] sample
);

  logic [9:0]          v10;
  logic [17:0]         scaled;
  logic [SAMPLE_W-1:0] q0;
  logic [10:0]         rem;
  logic [SAMPLE_W-1:0] q_ten;

  assign v10    = word[WORD_W-1:TEN_LSB];
  // v * 255 as (v << 8) - v
  assign scaled = {v10, 8'b0} - {8'b0, v10};
  // x / 1023: estimate x >> 10, remainder stays below twice the divisor
  assign q0     = scaled[17:10];
  assign rem    = {1'b0, scaled[9:0]} + {3'b0, q0};
  assign q_ten  = (rem >= TEN_FULL_SCALE) ? q0 + 8'd1 : q0;

  assign sample = ten_bit ? q_ten : word[SAMPLE_W-1:0];

endmodule

/* src/ycbcr_to_rgb_pixel_convert.sv */
// YCbCr to RGB pixel converter (bt.709 limited range, q10 matrix, clamp to 0..255).
// One pixel per clock sustained while the output does not stall; each beat passes
// through the four register stages in order: sample reduction, multiply, sum, round
// and clamp. Each stage holds its beat when the next is full and blocked, so a stall at
// the output backs up stage by stage and empty stages keep taking beats. ten_bit_r
// selects 10-bit MSB-aligned words (bits 15..6) over the low byte; write it while idle.
// Depends on ycc2rgb_pkg, ycc2rgb_in_if, ycc2rgb_out_if and ycc2rgb_sample.
`timescale 1ns / 1ps

module ycbcr_to_rgb_pixel_convert import ycc2rgb_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  ycc2rgb_in_if.sink    in_pix,
  ycc2rgb_out_if.source out_pix
);

  logic ten_bit_r;

  // stage valids and enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1: samples
  logic [SAMPLE_W-1:0] y_s_nxt, cb_s_nxt, cr_s_nxt;
  logic [SAMPLE_W-1:0] y_s_r, cb_s_r, cr_s_r;

  // stage 2: products
  logic signed [DIFF_W-1:0] y_d, cb_d, cr_d;
  logic signed [ACC_W-1:0]  p_y_nxt, p_rcr_nxt, p_gcb_nxt, p_gcr_nxt, p_bcb_nxt;
  logic signed [ACC_W-1:0]  p_y_r, p_rcr_r, p_gcb_r, p_gcr_r, p_bcb_r;

  // stage 3: sums
  logic signed [ACC_W-1:0] s_r_nxt, s_g_nxt, s_b_nxt;
  logic signed [ACC_W-1:0] s_r_r, s_g_r, s_b_r;

  // stage 4: clamped result
  logic [SAMPLE_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [SAMPLE_W-1:0] red_r, green_r, blue_r;

  assign en4 = !v4_r || out_pix.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_pix.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ten_bit_r <= 1'b0;
    end else if (cfg_we) begin
      ten_bit_r <= cfg_wdata;
    end
  end

  ycc2rgb_sample u_y  (.ten_bit(ten_bit_r), .word(in_pix.luma_word), .sample(y_s_nxt));
  ycc2rgb_sample u_cb (.ten_bit(ten_bit_r), .word(in_pix.cb_word),   .sample(cb_s_nxt));
  ycc2rgb_sample u_cr (.ten_bit(ten_bit_r), .word(in_pix.cr_word),   .sample(cr_s_nxt));

  assign y_d  = $signed({2'b00, y_s_r})  - Y_OFFSET;
  assign cb_d = $signed({2'b00, cb_s_r}) - C_OFFSET;
  assign cr_d = $signed({2'b00, cr_s_r}) - C_OFFSET;

  assign p_y_nxt   = y_d * COEF_Y + ROUND_HALF;
  assign p_rcr_nxt = cr_d * COEF_R_CR;
  assign p_gcb_nxt = cb_d * COEF_G_CB;
  assign p_gcr_nxt = cr_d * COEF_G_CR;
  assign p_bcb_nxt = cb_d * COEF_B_CB;

  assign s_r_nxt = p_y_r + p_rcr_r;
  assign s_g_nxt = p_y_r - p_gcb_r - p_gcr_r;
  assign s_b_nxt = p_y_r + p_bcb_r;

  // floor shift then clamp: negative gives 0, anything past a byte gives 255
  function automatic logic [SAMPLE_W-1:0] round_clamp(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-FRAC_BITS-1:0] q;
    q = v[ACC_W-1:FRAC_BITS];
    if (q[ACC_W-FRAC_BITS-1]) begin
      round_clamp = '0;
    end else if (q[ACC_W-FRAC_BITS-2:SAMPLE_W] != '0) begin
      round_clamp = '1;
    end else begin
      round_clamp = q[SAMPLE_W-1:0];
    end
  endfunction

  assign red_nxt   = round_clamp(s_r_r);
  assign green_nxt = round_clamp(s_g_r);
  assign blue_nxt  = round_clamp(s_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_pix.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      y_s_r  <= y_s_nxt;
      cb_s_r <= cb_s_nxt;
      cr_s_r <= cr_s_nxt;
    end
    if (en2) begin
      p_y_r   <= p_y_nxt;
      p_rcr_r <= p_rcr_nxt;
      p_gcb_r <= p_gcb_nxt;
      p_gcr_r <= p_gcr_nxt;
      p_bcb_r <= p_bcb_nxt;
    end
    if (en3) begin
      s_r_r <= s_r_nxt;
      s_g_r <= s_g_nxt;
      s_b_r <= s_b_nxt;
    end
    if (en4) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_pix.valid = v4_r;
  assign out_pix.red   = red_r;
  assign out_pix.green = green_r;
  assign out_pix.blue  = blue_r;

  // an accepted beat lands in stage 1
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> v1_r)
    else $error("accepted beat missing from stage 1");

  // a full stage 2 whose successor is blocked keeps its beat and its luma, red and blue products
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !en3 |=> v2_r && $stable(p_y_r) && $stable(p_rcr_r) && $stable(p_bcb_r))
    else $error("stage 2 lost its beat under stall");

  // a full sum stage moves into the output stage whenever it is free
  a_s3_to_s4: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en4 |=> v4_r)
    else $error("beat dropped between sum and output stage");

  // the mode register follows the configuration write
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> ten_bit_r == $past(cfg_wdata))
    else $error("mode register did not take the write");

endmodule
